[rtl/pancake_sort_descending_top_defines.svh]
// Assertion macros used by the top-level RTL.
`ifndef PANCAKE_SORT_DESCENDING_TOP_DEFINES_SVH
`define PANCAKE_SORT_DESCENDING_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PSD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PSD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/psd_pkg.sv]
package psd_pkg;

	localparam int PSD_DEPTH = 16;
	localparam int VALUE_W   = 32;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PASS,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_DECIDE,
		ST_FL_CHK,
		ST_FL_RD,
		ST_FL_CAP,
		ST_FL_WR,
		ST_FIRST_RD,
		ST_EMIT_FIRST,
		ST_EMIT_RD,
		ST_EMIT
	} psd_state_t;

endpackage

[rtl/psd_if.sv]
interface psd_item_if import psd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      last;

	modport source (output valid, value, last, input ready);
	modport sink (input valid, value, last, output ready);
endinterface

interface psd_result_if import psd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value_res;
	logic                      last_res;
	logic                      dropped;

	modport source (output valid, value_res, last_res, dropped, input ready);
	modport sink (input valid, value_res, last_res, dropped, output ready);
endinterface

[rtl/psd_ram.sv]
module psd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[rtl/pancake_sort_descending_top.sv]
// Loading: one beat per cycle, no result until the beat marked last.
// Sorting, per pass: pass control, a max search over the unsorted part, then up to two
// flips that swap pairs by store read, capture and write; the single shared comparator
// and the one-write-port store set the pace. After the last pass, the final pass check,
// store read and emit states lead to the first result. Emitting: the first result takes
// no input beat, each later one is sent per accepted input beat after a store read. Reset clears control only.
module pancake_sort_descending_top import psd_pkg::*; #(
	parameter int DEPTH = PSD_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	psd_item_if.sink            item,
	psd_result_if.source        result
);

	`include "pancake_sort_descending_top_defines.svh"

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	psd_state_t state_q, state_d;

	logic [CW-1:0]             cnt_q, cnt_d;
	logic [CW-1:0]             pass_q, pass_d;
	logic [CW-1:0]             scan_q, scan_d;
	logic [IW-1:0]             maxpos_q, maxpos_d;
	logic signed [VALUE_W-1:0] maxval_q, maxval_d;
	logic [IW-1:0]             lo_q, lo_d;
	logic [IW-1:0]             hi_q, hi_d;
	logic                      second_q, second_d;
	logic [VALUE_W-1:0]        hold_q, hold_d;
	logic                      ovf_q, ovf_d;
	logic                      res_valid_q, res_valid_d;
	logic [VALUE_W-1:0]        res_value_q, res_value_d;
	logic                      res_last_q, res_last_d;
	logic                      res_dropped_q, res_dropped_d;

	logic                      we;
	logic [IW-1:0]             waddr;
	logic [VALUE_W-1:0]        wdata;
	logic [IW-1:0]             raddr_a, raddr_b;
	logic signed [VALUE_W-1:0] rdata_a;
	logic [VALUE_W-1:0]        rdata_b;

	logic [CW-1:0]             n_m1;
	logic [IW-1:0]             nm1_idx;
	logic [IW-1:0]             pass_idx;
	logic [CW-1:0]             pass_inc;
	logic [CW-1:0]             scan_inc;
	logic                      fin;
	logic                      out_free;
	logic                      item_acc;

	psd_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	assign n_m1     = cnt_q - CW'(1);
	assign nm1_idx  = n_m1[IW-1:0];
	assign pass_idx = pass_q[IW-1:0];
	assign pass_inc = pass_q + CW'(1);
	assign scan_inc = scan_q + CW'(1);
	assign fin      = (pass_inc >= cnt_q);
	assign out_free = !res_valid_q || result.ready;
	assign item_acc = item.valid && item.ready;

	assign result.valid     = res_valid_q;
	assign result.value_res = res_value_q;
	assign result.last_res  = res_last_q;
	assign result.dropped   = res_dropped_q;

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		pass_d        = pass_q;
		scan_d        = scan_q;
		maxpos_d      = maxpos_q;
		maxval_d      = maxval_q;
		lo_d          = lo_q;
		hi_d          = hi_q;
		second_d      = second_q;
		hold_d        = hold_q;
		ovf_d         = ovf_q;
		res_valid_d   = res_valid_q;
		res_value_d   = res_value_q;
		res_last_d    = res_last_q;
		res_dropped_d = res_dropped_q;
		we            = 1'b0;
		waddr         = cnt_q[IW-1:0];
		wdata         = item.value;
		raddr_a       = pass_idx;
		raddr_b       = hi_q;
		item.ready    = 1'b0;

		// drop the result once taken
		if (res_valid_q && result.ready) begin
			res_valid_d = 1'b0;
		end

		case (state_q)
			ST_LOAD: begin
				item.ready = 1'b1;
				if (item_acc) begin
					if (cnt_q < CW'(DEPTH)) begin
						we    = 1'b1;
						cnt_d = cnt_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (item.last) begin
						pass_d  = '0;
						state_d = ST_PASS;
					end
				end
			end
			ST_PASS: begin
				if (pass_inc < cnt_q) begin
					scan_d   = pass_q;
					maxpos_d = pass_idx;
					state_d  = ST_SCAN_RD;
				end else begin
					pass_d  = '0;
					state_d = ST_FIRST_RD;
				end
			end
			ST_SCAN_RD: begin
				raddr_a = scan_q[IW-1:0];
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				// strict compare keeps the lowest position among equal maxima
				if (scan_q == pass_q || rdata_a > maxval_q) begin
					maxval_d = rdata_a;
					maxpos_d = scan_q[IW-1:0];
				end
				scan_d = scan_inc;
				if (scan_inc < cnt_q) begin
					state_d = ST_SCAN_RD;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (maxpos_q == pass_idx) begin
					pass_d  = pass_inc;
					state_d = ST_PASS;
				end else if (maxpos_q != nm1_idx) begin
					lo_d     = maxpos_q;
					hi_d     = nm1_idx;
					second_d = 1'b0;
					state_d  = ST_FL_CHK;
				end else begin
					lo_d     = pass_idx;
					hi_d     = nm1_idx;
					second_d = 1'b1;
					state_d  = ST_FL_CHK;
				end
			end
			ST_FL_CHK: begin
				if (lo_q < hi_q) begin
					state_d = ST_FL_RD;
				end else if (!second_q) begin
					// max is on top now: flip it down into place
					lo_d     = pass_idx;
					hi_d     = nm1_idx;
					second_d = 1'b1;
				end else begin
					pass_d  = pass_inc;
					state_d = ST_PASS;
				end
			end
			ST_FL_RD: begin
				raddr_a = lo_q;
				raddr_b = hi_q;
				state_d = ST_FL_CAP;
			end
			ST_FL_CAP: begin
				we      = 1'b1;
				waddr   = hi_q;
				wdata   = rdata_a;
				hold_d  = rdata_b;
				state_d = ST_FL_WR;
			end
			ST_FL_WR: begin
				we      = 1'b1;
				waddr   = lo_q;
				wdata   = hold_q;
				lo_d    = lo_q + IW'(1);
				hi_d    = hi_q - IW'(1);
				state_d = ST_FL_CHK;
			end
			ST_FIRST_RD: begin
				state_d = ST_EMIT_FIRST;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT_FIRST, ST_EMIT: begin
				if (state_q == ST_EMIT) begin
					item.ready = out_free;
				end
				if ((state_q == ST_EMIT_FIRST && out_free) || (state_q == ST_EMIT && item_acc))
				begin
					res_valid_d   = 1'b1;
					res_value_d   = rdata_a;
					res_last_d    = fin;
					res_dropped_d = ovf_q;
					if (fin) begin
						cnt_d    = '0;
						pass_d   = '0;
						maxpos_d = '0;
						ovf_d    = 1'b0;
						state_d  = ST_LOAD;
					end else begin
						pass_d  = pass_inc;
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pass_q      <= '0;
			scan_q      <= '0;
			maxpos_q    <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			second_q    <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			cnt_q       <= cnt_d;
			pass_q      <= pass_d;
			scan_q      <= scan_d;
			maxpos_q    <= maxpos_d;
			lo_q        <= lo_d;
			hi_q        <= hi_d;
			second_q    <= second_d;
			ovf_q       <= ovf_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		maxval_q      <= maxval_d;
		hold_q        <= hold_d;
		res_value_q   <= res_value_d;
		res_last_q    <= res_last_d;
		res_dropped_q <= res_dropped_d;
	end

	`PSD_ASSERT_IMP(a_busy_not_ready, (state_q != ST_LOAD && state_q != ST_EMIT), !item.ready)
	`PSD_ASSERT_IMP(a_count_bound, 1'b1, cnt_q <= CW'(DEPTH))
	`PSD_ASSERT_IMP(a_flip_order, state_q == ST_FL_RD, lo_q < hi_q)
	`PSD_ASSERT_IMP(a_max_range, state_q == ST_DECIDE,
		(maxpos_q >= pass_idx) && (CW'(maxpos_q) < cnt_q))
	`PSD_ASSERT_NXT(a_fin_reload, (state_q == ST_EMIT && item_acc && fin),
		(state_q == ST_LOAD) && (cnt_q == '0) && !ovf_q)

endmodule

[tb/sv/pancake_sort_descending_top_checker.sv]
`timescale 1ns / 100ps

module pancake_sort_descending_top_checker import psd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	psd_item_if    item,
	psd_result_if  result,
	output int     fails,
	output int     pending
);

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_res;
		logic                      last_res;
		logic                      dropped;
	} sorted_beat_t;

	// Own copy of the stack and the emit position.
	logic signed [VALUE_W-1:0] stack_mem [PSD_DEPTH];
	int unsigned               held;
	int unsigned               out_ptr;
	bit                        overflow;
	bit                        emitting;
	sorted_beat_t              sorted_due [$];

	task log_mismatch(input string field, input logic signed [VALUE_W-1:0] got,
			input logic signed [VALUE_W-1:0] want);
		$display("%0t: mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
		fails++;
	endtask

	// Reverse the top k of the held elements.
	task flip_top(input int unsigned k);
		int unsigned               lo;
		int unsigned               hi;
		logic signed [VALUE_W-1:0] tmp;
		lo = held - k;
		hi = held - 1;
		while (lo < hi) begin
			tmp           = stack_mem[lo];
			stack_mem[lo] = stack_mem[hi];
			stack_mem[hi] = tmp;
			lo++;
			hi--;
		end
	endtask

	task pancake_flip_sort;
		int unsigned p;
		int unsigned i;
		int unsigned mx;
		for (p = 0; p + 1 < held; p++) begin
			mx = p;
			for (i = p + 1; i < held; i++)
				if (stack_mem[i] > stack_mem[mx])
					mx = i;
			if (mx != p) begin
				if (mx != held - 1)
					flip_top(held - mx);
				flip_top(held - p);
			end
		end
	endtask

	task queue_next_sorted;
		sorted_beat_t b;
		b.value_res = stack_mem[out_ptr];
		b.last_res  = (out_ptr + 1 >= held);
		b.dropped   = overflow;
		sorted_due.push_back(b);
		if (b.last_res) begin
			held     = 0;
			out_ptr  = 0;
			overflow = 0;
			emitting = 0;
		end else begin
			out_ptr++;
		end
	endtask

	task predict_beat(input logic signed [VALUE_W-1:0] v, input logic lst);
		if (emitting) begin
			queue_next_sorted();
		end else begin
			if (held < PSD_DEPTH) begin
				stack_mem[held] = v;
				held++;
			end else begin
				overflow = 1;
			end
			if (lst) begin
				pancake_flip_sort();
				out_ptr  = 0;
				emitting = 1;
				queue_next_sorted();
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sorted_beat_t want;
		if (!arst_n) begin
			held     = 0;
			out_ptr  = 0;
			overflow = 0;
			emitting = 0;
			fails    = 0;
			sorted_due.delete();
		end else begin
			// Predict first so a same-edge result can find its expectation.
			if (item.valid && item.ready)
				predict_beat(item.value, item.last);
			if (result.valid && result.ready) begin
				if (sorted_due.size() == 0) begin
					$display("%0t: result beat with nothing expected, value %0d",
						$realtime, result.value_res);
					fails++;
				end else begin
					want = sorted_due.pop_front();
					if (result.value_res !== want.value_res)
						log_mismatch("value_res", result.value_res, want.value_res);
					if (result.last_res !== want.last_res)
						log_mismatch("last_res", VALUE_W'(result.last_res),
							VALUE_W'(want.last_res));
					if (result.dropped !== want.dropped)
						log_mismatch("dropped", VALUE_W'(result.dropped),
							VALUE_W'(want.dropped));
				end
			end
		end
		pending = sorted_due.size();
	end

endmodule

[tb/sv/pancake_sort_descending_top_tb.sv]
`timescale 1ns / 100ps

module pancake_sort_descending_top_tb;
	import psd_pkg::*;

	localparam int ITEM_TARGET = 1250;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fffffff;
	localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh80000000;

	typedef enum int {MIX_WIDE, MIX_DUPES, MIX_EXTREME} value_mix_t;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   cycles = 0;
	int   beats_sent;
	int   send_idle;
	int   recv_idle;

	psd_item_if   item_ch ();
	psd_result_if result_ch ();

	pancake_sort_descending_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	pancake_sort_descending_top_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial clk = 0;
	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("pancake_sort_descending_top_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk)
		result_ch.ready <= ($urandom_range(99) >= recv_idle);

	// Idle mix follows how far the stimulus has come.
	task update_idle_mix;
		if (beats_sent < ITEM_TARGET / 3) begin
			send_idle = 27;
			recv_idle = 75;
		end else if (beats_sent < 2 * ITEM_TARGET / 3) begin
			send_idle = 75;
			recv_idle = 27;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	task send_beat(input logic signed [VALUE_W-1:0] v, input logic lst);
		while ($urandom_range(99) < send_idle) begin
			item_ch.valid <= 0;
			@(posedge clk);
		end
		item_ch.valid <= 1;
		item_ch.value <= v;
		item_ch.last  <= lst;
		do @(posedge clk); while (!item_ch.ready);
		beats_sent++;
		update_idle_mix();
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value(input value_mix_t mix);
		logic signed [VALUE_W-1:0] v;
		case (mix)
			MIX_DUPES: begin
				v = $urandom_range(7) - 3;
			end
			MIX_EXTREME: begin
				case ($urandom_range(3))
					0: v = V_MAX;
					1: v = V_MIN;
					2: v = 0;
					default: v = -1;
				endcase
			end
			default: begin
				v = $urandom;
			end
		endcase
		return v;
	endfunction

	// Pull the rest of the sorted stack; the beat fields are don't-care here.
	task drain_stack(input int loaded);
		int n;
		n = (loaded > PSD_DEPTH) ? PSD_DEPTH : loaded;
		repeat (n - 1)
			send_beat($urandom, 1'($urandom_range(1)));
	endtask

	task send_list(input logic signed [VALUE_W-1:0] vals [$]);
		foreach (vals[i])
			send_beat(vals[i], i == vals.size() - 1);
		drain_stack(vals.size());
	endtask

	task send_random_stack;
		int         len;
		value_mix_t mix;
		case ($urandom_range(9))
			0: len = PSD_DEPTH + 1 + $urandom_range(4);
			1: len = PSD_DEPTH;
			2: len = 1 + $urandom_range(2);
			default: len = 1 + $urandom_range(PSD_DEPTH - 1);
		endcase
		mix = value_mix_t'($urandom_range(2));
		for (int i = 0; i < len; i++)
			send_beat(pick_value(mix), i == len - 1);
		drain_stack(len);
	endtask

	initial begin
		beats_sent      = 0;
		arst_n          = 0;
		item_ch.valid   = 0;
		item_ch.value   = 0;
		item_ch.last    = 0;
		update_idle_mix();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Single element, pair of extremes, ties, ascending run, descending run.
		send_list('{V_MAX});
		send_list('{V_MIN, V_MAX});
		send_list('{-32'sd1, 32'sd5, -32'sd1});
		send_list('{V_MIN, -32'sd1, 32'sd0, 32'sd1, V_MAX});
		send_list('{32'sd3, 32'sd2, 32'sd1});

		while (beats_sent < ITEM_TARGET)
			send_random_stack();

		item_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("pancake_sort_descending_top_tb: done, clean");
		end else begin
			$display("pancake_sort_descending_top_tb: done, errors");
		end
		$finish;
	end

endmodule

[pancake_sort_descending_top.f]
+incdir+rtl
rtl/psd_pkg.sv
rtl/psd_if.sv
rtl/psd_ram.sv
rtl/pancake_sort_descending_top.sv
tb/sv/pancake_sort_descending_top_checker.sv
tb/sv/pancake_sort_descending_top_tb.sv
